FILE: rtl/pfd_pkg.sv
// Shared types and constants for the PPM frame decoder with flight-mode select.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package pfd_pkg;

  localparam int unsigned NumChannels = 8;
  localparam int unsigned NumSlots    = NumChannels + 1;
  localparam int unsigned SlotW       = 4;
  localparam int unsigned CountW      = 16;
  localparam int unsigned RegIdxW     = 3;
  localparam int unsigned InDataW     = 24;
  localparam int unsigned OutDataW    = 24;

  localparam logic [SlotW-1:0] SlotNone  = SlotW'(0);
  localparam logic [SlotW-1:0] SlotFirst = SlotW'(1);
  localparam logic [SlotW-1:0] SlotChLast = SlotW'(NumChannels);
  localparam logic [SlotW-1:0] SlotRem   = SlotW'(NumSlots);
  localparam logic [SlotW-1:0] SlotCh6   = SlotW'(6);
  localparam logic [SlotW-1:0] SlotCh7   = SlotW'(7);

  typedef enum logic [RegIdxW-1:0] {
    REG_SYNC_THR = 3'd0,
    REG_LOW_MIN  = 3'd1,
    REG_LOW_MAX  = 3'd2,
    REG_MID_MIN  = 3'd3,
    REG_MID_MAX  = 3'd4
  } reg_idx_e;

  typedef enum logic [1:0] {
    MODE_MANUAL    = 2'd0,
    MODE_STABILIZE = 2'd1,
    MODE_AUTO      = 2'd2,
    MODE_AUTOTUNE  = 2'd3
  } ctrl_mode_e;

  localparam logic [CountW-1:0] SyncThrRst = 16'd3000;
  localparam logic [CountW-1:0] LowMinRst  = 16'd950;
  localparam logic [CountW-1:0] LowMaxRst  = 16'd1050;
  localparam logic [CountW-1:0] MidMinRst  = 16'd1450;
  localparam logic [CountW-1:0] MidMaxRst  = 16'd1550;

  typedef struct packed {
    logic [CountW-1:0] sync_thr;
    logic [CountW-1:0] low_min;
    logic [CountW-1:0] low_max;
    logic [CountW-1:0] mid_min;
    logic [CountW-1:0] mid_max;
  } cfg_t;

  typedef struct packed {
    logic [CountW-1:0] capture_count;
    logic              pin_high;
  } event_t;

  typedef struct packed {
    ctrl_mode_e        ctrl_mode;
    logic              clear_counter;
    logic              resynced;
    logic [CountW-1:0] slot_width;
    logic [SlotW-1:0]  updated_slot;
  } result_t;

endpackage

`default_nettype wire

FILE: rtl/pfd_cfg_regs.sv
// Configuration register file: sync threshold and the two switch windows.
// Depends on pfd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pfd_cfg_regs
  import pfd_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [RegIdxW-1:0] cfg_idx_i,
  input  wire logic [CountW-1:0]  cfg_wdata_i,
  output cfg_t                    cfg_o
);

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_SYNC_THR: cfg_d.sync_thr = cfg_wdata_i;
        REG_LOW_MIN:  cfg_d.low_min  = cfg_wdata_i;
        REG_LOW_MAX:  cfg_d.low_max  = cfg_wdata_i;
        REG_MID_MIN:  cfg_d.mid_min  = cfg_wdata_i;
        REG_MID_MAX:  cfg_d.mid_max  = cfg_wdata_i;
        default:      cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.sync_thr <= SyncThrRst;
      cfg_q.low_min  <= LowMinRst;
      cfg_q.low_max  <= LowMaxRst;
      cfg_q.mid_min  <= MidMinRst;
      cfg_q.mid_max  <= MidMaxRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

FILE: rtl/pfd_decode.sv
// Frame decoder state (slot index, last capture, channels 6/7) and per-beat
// result logic including flight-mode selection. Depends on pfd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pfd_decode
  import pfd_pkg::*;
(
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  wire logic   fire_i,
  input  wire event_t evt_i,
  input  wire cfg_t   cfg_i,
  output result_t     res_o
);

  logic [SlotW-1:0]  slot_idx_q, slot_idx_d;
  logic [CountW-1:0] last_q, last_d;
  logic [CountW-1:0] ch6_q, ch6_d;
  logic [CountW-1:0] ch7_q, ch7_d;
  logic [CountW-1:0] width;
  logic              in_chan;
  logic              ch6_low, ch7_low, ch7_mid;

  assign width   = evt_i.capture_count - last_q;
  assign in_chan = (slot_idx_q >= SlotFirst) && (slot_idx_q <= SlotChLast);

  always_comb begin
    slot_idx_d  = slot_idx_q;
    last_d      = last_q;
    ch6_d       = ch6_q;
    ch7_d       = ch7_q;
    res_o.updated_slot  = SlotNone;
    res_o.slot_width    = '0;
    res_o.resynced      = 1'b0;
    res_o.clear_counter = 1'b0;
    if (evt_i.pin_high) begin
      if (in_chan) begin
        res_o.updated_slot = slot_idx_q;
        res_o.slot_width   = width;
        last_d             = evt_i.capture_count;
        if (slot_idx_q == SlotCh6) ch6_d = width;
        if (slot_idx_q == SlotCh7) ch7_d = width;
        if (width > cfg_i.sync_thr) begin
          res_o.resynced = 1'b1;
          slot_idx_d     = SlotFirst;
        end else begin
          slot_idx_d = slot_idx_q + SlotW'(1);
        end
      end else if (slot_idx_q == SlotRem) begin
        res_o.updated_slot  = slot_idx_q;
        res_o.slot_width    = width;
        res_o.clear_counter = 1'b1;
        last_d              = '0;
        slot_idx_d          = SlotFirst;
      end else begin
        last_d     = evt_i.capture_count;
        slot_idx_d = SlotFirst;
      end
    end

    ch6_low = (ch6_d > cfg_i.low_min) && (ch6_d < cfg_i.low_max);
    ch7_low = (ch7_d > cfg_i.low_min) && (ch7_d < cfg_i.low_max);
    ch7_mid = (ch7_d > cfg_i.mid_min) && (ch7_d < cfg_i.mid_max);

    if (ch6_low)      res_o.ctrl_mode = MODE_MANUAL;
    else if (ch7_low) res_o.ctrl_mode = MODE_STABILIZE;
    else if (ch7_mid) res_o.ctrl_mode = MODE_AUTO;
    else              res_o.ctrl_mode = MODE_AUTOTUNE;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_idx_q <= SlotNone;
      last_q     <= '0;
      ch6_q      <= '0;
      ch7_q      <= '0;
    end else if (fire_i) begin
      slot_idx_q <= slot_idx_d;
      last_q     <= last_d;
      ch6_q      <= ch6_d;
      ch7_q      <= ch7_d;
    end
  end

  a_slot_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    slot_idx_q <= SlotRem)
    else $error("slot index beyond remainder slot");

  a_clr_zeroes_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && res_o.clear_counter |=> last_q == '0 && slot_idx_q == SlotFirst)
    else $error("remainder slot did not restart frame");

  a_resync_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && res_o.resynced |=> slot_idx_q == SlotFirst)
    else $error("resync did not restart frame");

  a_low_no_update: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && !evt_i.pin_high |=> $stable(slot_idx_q) && $stable(last_q))
    else $error("low pin level changed decoder state");

endmodule

`default_nettype wire

FILE: rtl/ppm_frame_decoder_mode_select.sv
// Top level of the PPM frame decoder: input register, decoder, result register.
// Depends on pfd_pkg, pfd_cfg_regs and pfd_decode.
`timescale 1ns / 1ps
`default_nettype none

// Decodes a PPM capture stream into channel slot widths and a flight mode.
// Every accepted beat yields exactly one result beat. One beat per clock is
// sustained while the output is not stalled by m_axis_tready; a beat lands
// in the input register, then the decoder updates its state and loads the
// result register once the output can take it. The decoder's state update
// per beat sets the rate. Configuration writes take effect on the next clock
// and must be issued while no beat is in flight.

module ppm_frame_decoder_mode_select
  import pfd_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic [RegIdxW-1:0]  cfg_idx_i,
  input  wire logic [CountW-1:0]   cfg_wdata_i,
  input  wire logic                s_axis_tvalid,
  output logic                     s_axis_tready,
  // [15:0] capture_count, [16] pin_high, [23:17] zero
  input  wire logic [InDataW-1:0]  s_axis_tdata,
  output logic                     m_axis_tvalid,
  input  wire logic                m_axis_tready,
  // [3:0] updated_slot, [19:4] slot_width, [20] resynced,
  // [21] clear_counter, [23:22] ctrl_mode
  output logic [OutDataW-1:0]      m_axis_tdata
);

  cfg_t    cfg;
  event_t  in_q;
  logic    in_valid_q;
  result_t res;
  result_t out_q;
  logic    out_valid_q;
  logic    advance;

  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;

  pfd_cfg_regs u_cfg (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_idx_i,
    .cfg_wdata_i,
    .cfg_o (cfg)
  );

  pfd_decode u_dec (
    .clk_i,
    .rst_ni,
    .fire_i (advance),
    .evt_i  (in_q),
    .cfg_i  (cfg),
    .res_o  (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s_axis_tready) in_valid_q <= s_axis_tvalid;
      if (advance) out_valid_q <= 1'b1;
      else if (m_axis_tready) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_q.capture_count <= s_axis_tdata[CountW-1:0];
      in_q.pin_high      <= s_axis_tdata[CountW];
    end
    if (advance) out_q <= res;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_q;

endmodule

`default_nettype wire
